>>> rtl/gtg_pkg.sv
// Shared types, constants and the arctangent table for the go-to-goal controller.
package gtg_pkg;

	localparam int CORDIC_STAGES = 16;
	localparam int NUM_STAGES    = (CORDIC_STAGES > 24) ? 24 : CORDIC_STAGES;

	// CORDIC datapath widths: x/y carry 8 guard bits over Q4.11, z is Q.20
	localparam int XW = 28;
	localparam int ZW = 24;

	localparam logic signed [ZW-1:0] HALF_PI_Q20  = ZW'(1647099);
	localparam logic        [19:0]   INV_GAIN_Q20 = 20'd636751;

	localparam logic [11:0] ANG_GAIN_RST = 12'd768;
	localparam logic [11:0] LIN_GAIN_RST = 12'd256;
	localparam logic [14:0] ANG_TOL_RST  = 15'd819;
	localparam logic [14:0] DIST_TOL_RST = 15'd205;

	typedef enum logic [1:0] {
		REG_ANG_GAIN = 2'd0,
		REG_LIN_GAIN = 2'd1,
		REG_ANG_TOL  = 2'd2,
		REG_DIST_TOL = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic signed [15:0] goal_x;
		logic signed [15:0] goal_y;
		logic signed [15:0] pose_x;
		logic signed [15:0] pose_y;
		logic signed [15:0] pose_heading;
	} req_t;

	typedef struct packed {
		logic signed [17:0] angular_rate;
		logic        [16:0] linear_speed;
		logic               goal_reached;
	} rsp_t;

	typedef struct packed {
		logic [11:0] angular_gain;
		logic [11:0] linear_gain;
		logic [14:0] angle_tolerance;
		logic [14:0] distance_tolerance;
	} cfg_t;

	// Data handed from cell to cell
	typedef struct packed {
		logic               valid;
		logic               zero;
		logic signed [15:0] heading;
		logic signed [XW-1:0] x;
		logic signed [XW-1:0] y;
		logic signed [ZW-1:0] z;
	} cordic_t;

	function automatic logic signed [ZW-1:0] atan_q20(input logic [4:0] idx);
		logic signed [ZW-1:0] a;
		case (idx)
			5'd0:    a = ZW'(823550);
			5'd1:    a = ZW'(486170);
			5'd2:    a = ZW'(256879);
			5'd3:    a = ZW'(130396);
			5'd4:    a = ZW'(65451);
			5'd5:    a = ZW'(32757);
			5'd6:    a = ZW'(16383);
			5'd7:    a = ZW'(8192);
			5'd8:    a = ZW'(4096);
			5'd9:    a = ZW'(2048);
			5'd10:   a = ZW'(1024);
			5'd11:   a = ZW'(512);
			5'd12:   a = ZW'(256);
			5'd13:   a = ZW'(128);
			5'd14:   a = ZW'(64);
			5'd15:   a = ZW'(32);
			5'd16:   a = ZW'(16);
			5'd17:   a = ZW'(8);
			5'd18:   a = ZW'(4);
			5'd19:   a = ZW'(2);
			5'd20:   a = ZW'(1);
			default: a = '0;
		endcase
		return a;
	endfunction

endpackage

>>> rtl/gtg_pre.sv
// Input stage: goal-minus-pose vector, guard bits and quadrant pre-rotation.
module gtg_pre import gtg_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  req_t    req,
	output cordic_t pre_s1
);

	logic signed [16:0]   dx;
	logic signed [16:0]   dy;
	logic signed [XW-1:0] x0;
	logic signed [XW-1:0] y0;
	cordic_t              nxt;

	always_comb begin
		dx = 17'(signed'(req.goal_x)) - 17'(signed'(req.pose_x));
		dy = 17'(signed'(req.goal_y)) - 17'(signed'(req.pose_y));
		x0 = $signed({{(XW-25){dx[16]}}, dx, 8'b0});
		y0 = $signed({{(XW-25){dy[16]}}, dy, 8'b0});
		nxt.valid   = start;
		nxt.zero    = (dx == '0) && (dy == '0);
		nxt.heading = req.pose_heading;
		nxt.x       = x0;
		nxt.y       = y0;
		nxt.z       = '0;
		// left half plane: rotate by +-pi/2 into the right one
		if (x0 < 0) begin
			if (y0 >= 0) begin
				nxt.x = y0;
				nxt.y = -x0;
				nxt.z = HALF_PI_Q20;
			end else begin
				nxt.x = -y0;
				nxt.y = x0;
				nxt.z = -HALF_PI_Q20;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pre_s1 <= '0;
		end else begin
			pre_s1 <= nxt;
		end
	end

endmodule

>>> rtl/gtg_cordic_cell.sv
// One CORDIC vectoring micro-rotation with its output register.
module gtg_cordic_cell import gtg_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cordic_t              d,
	input  logic [4:0]           shift,
	input  logic signed [ZW-1:0] angle,
	output cordic_t              cell_s1
);

	logic signed [XW-1:0] xv;
	logic signed [XW-1:0] yv;
	logic signed [XW-1:0] xs;
	logic signed [XW-1:0] ys;
	logic signed [XW-1:0] x_nxt;
	logic signed [XW-1:0] y_nxt;
	logic signed [ZW-1:0] z_nxt;

	always_comb begin
		xv = d.x;
		yv = d.y;
		xs = xv >>> shift;
		ys = yv >>> shift;
		// drive y toward zero
		if (yv >= 0) begin
			x_nxt = xv + ys;
			y_nxt = yv - xs;
			z_nxt = d.z + angle;
		end else begin
			x_nxt = xv - ys;
			y_nxt = yv + xs;
			z_nxt = d.z - angle;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_s1 <= '0;
		end else begin
			cell_s1.valid   <= d.valid;
			cell_s1.zero    <= d.zero;
			cell_s1.heading <= d.heading;
			cell_s1.x       <= x_nxt;
			cell_s1.y       <= y_nxt;
			cell_s1.z       <= z_nxt;
		end
	end

endmodule

>>> rtl/gtg_post.sv
// Output stages: gain correction, heading error, proportional law, saturation.
module gtg_post import gtg_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  cordic_t d,
	input  cfg_t    cfg,
	output rsp_t    rsp,
	output logic    rsp_valid
);

	// stage 1: scale x by 1/K, round z to Q3.13
	logic        [XW-2:0]  xpos;
	logic signed [ZW:0]    zr;
	logic        [46:0]    prod_s1;
	logic signed [16:0]    bearing_s1;
	logic signed [15:0]    heading_s1;
	logic                  valid_s1;

	// stage 2: distance, heading error, decisions
	logic        [47:0]    dsum;
	logic        [16:0]    distance;
	logic signed [17:0]    err;
	logic        [17:0]    aerr;
	logic        [16:0]    dist_s2;
	logic signed [17:0]    err_s2;
	logic                  turn_s2;
	logic                  reached_s2;
	logic                  valid_s2;

	// stage 3: gain products
	logic signed [30:0]    angp_s3;
	logic        [28:0]    linp_s3;
	logic                  turn_s3;
	logic                  reached_s3;
	logic                  valid_s3;

	// stage 4: rounding and saturation
	logic signed [31:0]    asum;
	logic signed [20:0]    ang;
	logic        [29:0]    lsum;
	logic        [20:0]    lin;
	rsp_t                  nxt;

	always_comb begin
		xpos = d.x[XW-1] ? '0 : d.x[XW-2:0];
		zr   = (ZW+1)'(d.z) + (ZW+1)'(64);
	end

	always_ff @(posedge clk) begin
		// a goal sitting on the pose gives zero bearing and distance
		prod_s1    <= d.zero ? '0 : 47'(xpos) * 47'(INV_GAIN_Q20);
		bearing_s1 <= d.zero ? '0 : zr[23:7];
		heading_s1 <= d.heading;
	end

	always_comb begin
		dsum     = 48'(prod_s1) + 48'(64'd1 << 27);
		distance = dsum[44:28];
		err      = 18'(bearing_s1) - 18'(heading_s1);
		aerr     = err[17] ? 18'(-err) : 18'(err);
	end

	always_ff @(posedge clk) begin
		dist_s2    <= distance;
		err_s2     <= err;
		turn_s2    <= aerr > 18'(cfg.angle_tolerance);
		reached_s2 <= distance <= 17'(cfg.distance_tolerance);
	end

	always_ff @(posedge clk) begin
		angp_s3    <= $signed({1'b0, cfg.angular_gain}) * 31'(err_s2);
		linp_s3    <= cfg.linear_gain * 29'(dist_s2);
		turn_s3    <= turn_s2;
		reached_s3 <= reached_s2;
	end

	always_comb begin
		asum = 32'(angp_s3) + 32'sd1024;
		ang  = 21'(asum >>> 11);
		lsum = 30'(linp_s3) + 30'd256;
		lin  = lsum[29:9];
		nxt.angular_rate = '0;
		nxt.linear_speed = '0;
		nxt.goal_reached = 1'b0;
		if (turn_s3) begin
			if (ang > 21'sd131071) begin
				nxt.angular_rate = 18'sd131071;
			end else if (ang < -21'sd131072) begin
				nxt.angular_rate = -18'sd131072;
			end else begin
				nxt.angular_rate = ang[17:0];
			end
		end else if (reached_s3) begin
			nxt.goal_reached = 1'b1;
		end else begin
			nxt.linear_speed = (lin > 21'd131071) ? 17'd131071 : lin[16:0];
		end
	end

	always_ff @(posedge clk) begin
		rsp <= nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
			valid_s3  <= 1'b0;
			rsp_valid <= 1'b0;
		end else begin
			valid_s1  <= d.valid;
			valid_s2  <= valid_s1;
			valid_s3  <= valid_s2;
			rsp_valid <= valid_s3;
		end
	end

endmodule

>>> rtl/go_to_goal_p_controller.sv
// Top level: APB registers, input stage, CORDIC cell chain and output stages.
//
// Go-to-goal proportional controller. A request (goal and pose) is taken on
// any cycle with start high; busy is always low, so one request per clock is
// sustained. Each request gives exactly one result, shown on drive for one
// cycle with drive_valid high. The input stage register loads at the edge
// that takes the request; the request then passes through the CORDIC cell
// chain, one micro-rotation per cell per cycle, and four output stages (1/K
// scaling multiply, error and compare, gain multiply, rounding and
// saturation), and the result is taken at the edge that ends the cycle in
// which drive_valid is high. The result cannot be held off, so the receiver
// must take it in the cycle it appears. Write the registers only while no
// request is in flight.
module go_to_goal_p_controller import gtg_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  req_t        pose_req,
	output rsp_t        drive,
	output logic        drive_valid,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	cordic_t  chain [0:NUM_STAGES];

	assign busy   = 1'b0;
	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.angular_gain       <= ANG_GAIN_RST;
			cfg_q.linear_gain        <= LIN_GAIN_RST;
			cfg_q.angle_tolerance    <= ANG_TOL_RST;
			cfg_q.distance_tolerance <= DIST_TOL_RST;
		end else if (psel && penable && pwrite && pready) begin
			case (idx)
				REG_ANG_GAIN: cfg_q.angular_gain       <= pwdata[11:0];
				REG_LIN_GAIN: cfg_q.linear_gain        <= pwdata[11:0];
				REG_ANG_TOL:  cfg_q.angle_tolerance    <= pwdata[14:0];
				REG_DIST_TOL: cfg_q.distance_tolerance <= pwdata[14:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_ANG_GAIN: prdata = 32'(cfg_q.angular_gain);
			REG_LIN_GAIN: prdata = 32'(cfg_q.linear_gain);
			REG_ANG_TOL:  prdata = 32'(cfg_q.angle_tolerance);
			REG_DIST_TOL: prdata = 32'(cfg_q.distance_tolerance);
			default:      prdata = '0;
		endcase
	end

	gtg_pre u_pre (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start && !busy),
		.req    (pose_req),
		.pre_s1 (chain[0])
	);

	for (genvar g = 0; g < NUM_STAGES; g++) begin : g_cell
		gtg_cordic_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.d       (chain[g]),
			.shift   (5'(g)),
			.angle   (atan_q20(5'(g))),
			.cell_s1 (chain[g+1])
		);
	end

	gtg_post u_post (
		.clk       (clk),
		.arst_n    (arst_n),
		.d         (chain[NUM_STAGES]),
		.cfg       (cfg_q),
		.rsp       (drive),
		.rsp_valid (drive_valid)
	);

endmodule

>>> bench/go_to_goal_p_controller_tb.sv
// Testbench for the go-to-goal controller: drives requests and APB writes, checks each drive result.
`timescale 1ns / 100ps

import gtg_pkg::*;

class drive_scoreboard;
	localparam longint QUARTER_TURN = 1647099;  // pi/2 in Q.20
	localparam longint INV_K        = 636751;   // 1/K in Q.20

	cfg_t   regs;
	rsp_t   expected_q[$];
	longint arctan[24];
	int     errors;

	function new();
		arctan = '{823550, 486170, 256879, 130396, 65451, 32757, 16383, 8192,
			4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2, 1, 0, 0, 0};
		regs.angular_gain       = 12'd768;
		regs.linear_gain        = 12'd256;
		regs.angle_tolerance    = 15'd819;
		regs.distance_tolerance = 15'd205;
		errors = 0;
	endfunction

	// Distance (Q4.11) and bearing (Q3.13) of the vector dx, dy
	function void vector_to_goal(input longint dx, input longint dy,
			output longint distance, output longint bearing);
		longint x, y, z, xs, ys, t;
		if (dx == 0 && dy == 0) begin
			distance = 0;
			bearing = 0;
			return;
		end
		x = dx * 256;
		y = dy * 256;
		z = 0;
		// fold the left half plane into the right one
		if (x < 0) begin
			if (y >= 0) begin
				t = x; x = y; y = -t; z = QUARTER_TURN;
			end else begin
				t = x; x = -y; y = t; z = -QUARTER_TURN;
			end
		end
		for (int i = 0; i < NUM_STAGES; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y >= 0) begin
				x += ys; y -= xs; z += arctan[i];
			end else begin
				x -= ys; y += xs; z -= arctan[i];
			end
		end
		if (x < 0) x = 0;
		distance = (x * INV_K + (64'sd1 <<< 27)) >>> 28;
		bearing = (z + 64) >>> 7;
	endfunction

	function rsp_t predict(req_t r);
		longint distance, brg, err, mag, rate, speed;
		rsp_t   o;
		o = '0;
		vector_to_goal(longint'(r.goal_x) - longint'(r.pose_x),
			longint'(r.goal_y) - longint'(r.pose_y), distance, brg);
		err = brg - longint'(r.pose_heading);
		mag = (err < 0) ? -err : err;
		if (mag > longint'(regs.angle_tolerance)) begin
			rate = (longint'(regs.angular_gain) * err + 1024) >>> 11;
			if (rate > 131071) rate = 131071;
			if (rate < -131072) rate = -131072;
			o.angular_rate = 18'(rate);
		end else if (distance <= longint'(regs.distance_tolerance)) begin
			o.goal_reached = 1'b1;
		end else begin
			speed = (longint'(regs.linear_gain) * distance + 256) >>> 9;
			if (speed > 131071) speed = 131071;
			if (speed < 0) speed = 0;
			o.linear_speed = 17'(speed);
		end
		return o;
	endfunction

	function void note_request(req_t r);
		expected_q.push_back(predict(r));
	endfunction

	function void check_drive(rsp_t got);
		rsp_t want;
		if (expected_q.size() == 0) begin
			errors++;
			$display("%0t: drive result with no request pending: ang %0d lin %0d reached %0b",
				$time, got.angular_rate, got.linear_speed, got.goal_reached);
			return;
		end
		want = expected_q.pop_front();
		if (got.angular_rate !== want.angular_rate) begin
			errors++;
			$display("%0t: angular_rate expected %0d got %0d",
				$time, want.angular_rate, got.angular_rate);
		end
		if (got.linear_speed !== want.linear_speed) begin
			errors++;
			$display("%0t: linear_speed expected %0d got %0d",
				$time, want.linear_speed, got.linear_speed);
		end
		if (got.goal_reached !== want.goal_reached) begin
			errors++;
			$display("%0t: goal_reached expected %0b got %0b",
				$time, want.goal_reached, got.goal_reached);
		end
	endfunction

	function int outstanding();
		return expected_q.size();
	endfunction

	function void write_reg(reg_idx_t idx, logic [31:0] val);
		case (idx)
			REG_ANG_GAIN: regs.angular_gain       = val[11:0];
			REG_LIN_GAIN: regs.linear_gain        = val[11:0];
			REG_ANG_TOL:  regs.angle_tolerance    = val[14:0];
			REG_DIST_TOL: regs.distance_tolerance = val[14:0];
			default: ;
		endcase
	endfunction
endclass

module go_to_goal_p_controller_tb;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	req_t        pose_req = '0;
	rsp_t        drive;
	logic        drive_valid;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	drive_scoreboard sb;

	always #1 clk = ~clk;

	go_to_goal_p_controller DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.pose_req    (pose_req),
		.drive       (drive),
		.drive_valid (drive_valid),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready)
	);

	always @(posedge clk) begin
		if (arst_n && drive_valid)
			sb.check_drive(drive);
	end

	function automatic logic signed [15:0] clamp16(longint v);
		if (v > 32767) return 16'sd32767;
		if (v < -32768) return -16'sd32768;
		return 16'(v);
	endfunction

	function automatic longint spread(longint span);
		return longint'($urandom_range(32'(2 * span))) - span;
	endfunction

	function automatic req_t pose_item(longint gx, longint gy, longint px, longint py,
			longint hd);
		req_t r;
		r.goal_x = 16'(gx);
		r.goal_y = 16'(gy);
		r.pose_x = 16'(px);
		r.pose_y = 16'(py);
		r.pose_heading = 16'(hd);
		return r;
	endfunction

	// Heading chosen so that the heading error comes out as off
	function automatic req_t aimed_item(longint gx, longint gy, longint px, longint py,
			longint off);
		longint distance, brg;
		sb.vector_to_goal(gx - px, gy - py, distance, brg);
		return pose_item(gx, gy, px, py, clamp16(brg - off));
	endfunction

	// x offset whose computed distance lands exactly on target
	function automatic longint reach_dx(longint target);
		longint distance, brg;
		for (longint d = target - 6; d <= target + 6; d++) begin
			sb.vector_to_goal(d, 0, distance, brg);
			if (distance == target) return d;
		end
		return target;
	endfunction

	function automatic req_t make_request();
		req_t   r;
		int     kind;
		longint distance, brg, span, off;
		r.goal_x = 16'($urandom);
		r.goal_y = 16'($urandom);
		r.pose_x = 16'($urandom);
		r.pose_y = 16'($urandom);
		r.pose_heading = 16'($urandom);
		kind = $urandom_range(99);
		if (kind >= 92) begin
			r.pose_x = r.goal_x;
			r.pose_y = r.goal_y;
		end else if (kind >= 65) begin
			// close to the goal, around the distance tolerance
			span = longint'(sb.regs.distance_tolerance) * 2 + 16;
			if (span > 20000) span = 20000;
			r.pose_x = clamp16(longint'(r.goal_x) + spread(span));
			r.pose_y = clamp16(longint'(r.goal_y) + spread(span));
		end
		if (kind >= 30 && $urandom_range(3) != 0) begin
			sb.vector_to_goal(longint'(r.goal_x) - longint'(r.pose_x),
				longint'(r.goal_y) - longint'(r.pose_y), distance, brg);
			span = longint'(sb.regs.angle_tolerance) + 8;
			case ($urandom_range(5))
				0: off = span - 8;
				1: off = 8 - span;
				default: off = spread(span);
			endcase
			r.pose_heading = clamp16(brg - off);
		end
		return r;
	endfunction

	task automatic send_request(req_t r);
		@(negedge clk);
		start = 1'b1;
		pose_req = r;
		do @(posedge clk); while (busy);
		sb.note_request(r);
	endtask

	task automatic idle_cycles(int n);
		repeat (n) begin
			@(negedge clk);
			start = 1'b0;
			pose_req = pose_item($urandom, $urandom, $urandom, $urandom, $urandom);
		end
	endtask

	task automatic wait_drained();
		idle_cycles(1);
		while (sb.outstanding() != 0) @(posedge clk);
	endtask

	// Waits until every request is answered, then waits on with margin
	task automatic drain();
		wait_drained();
		repeat (30) @(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [31:0] val);
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = {idx, 2'b00};
		pwdata = val;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		sb.write_reg(idx, val);
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	task automatic set_regs(logic [31:0] ang, logic [31:0] lin, logic [31:0] atol,
			logic [31:0] dtol);
		write_reg(REG_ANG_GAIN, ang);
		write_reg(REG_LIN_GAIN, lin);
		write_reg(REG_ANG_TOL, atol);
		write_reg(REG_DIST_TOL, dtol);
	endtask

	task automatic run_directed();
		longint atol, d;
		atol = longint'(sb.regs.angle_tolerance);
		d = reach_dx(longint'(sb.regs.distance_tolerance));
		send_request(pose_item(0, 0, 0, 0, 0));
		send_request(pose_item(1234, -567, 1234, -567, 32767));
		send_request(pose_item(32767, 32767, -32768, -32768, 0));
		send_request(pose_item(-32768, -32768, 32767, 32767, -32768));
		send_request(pose_item(-32768, 32767, 32767, -32768, 32767));
		send_request(pose_item(32767, -32768, -32768, 32767, -32768));
		// aimed requests on the axes and on either side of the negative x axis
		send_request(aimed_item(1000, 0, 0, 0, 0));
		send_request(aimed_item(-1000, 5, 0, 0, 0));
		send_request(aimed_item(-1000, -5, 0, 0, 0));
		send_request(aimed_item(0, -1000, 0, 0, 0));
		send_request(aimed_item(-1000, 0, 0, 0, 0));
		// heading error right on the angle tolerance and just past it
		send_request(aimed_item(3000, 1000, 0, 0, atol));
		send_request(aimed_item(3000, 1000, 0, 0, -atol));
		send_request(aimed_item(3000, 1000, 0, 0, atol + 1));
		send_request(aimed_item(3000, 1000, 0, 0, -atol - 1));
		// distance right on the distance tolerance and either side
		send_request(aimed_item(d, 0, 0, 0, 0));
		send_request(aimed_item(d + 1, 0, 0, 0, 0));
		send_request(aimed_item(d - 1, 0, 0, 0, 0));
		send_request(aimed_item(20000, -20000, -12768, 12767, 0));
		wait_drained();
		send_request(aimed_item(-300, 700, 100, 100, 50));
		send_request(pose_item(-1, -1, 0, 0, -1));
		drain();
	endtask

	task automatic run_phase(int count, int idle_pct);
		for (int k = 0; k < count; k++) begin
			if ((k % 64) >= 12) begin
				while ($urandom_range(99) < idle_pct) idle_cycles(1);
			end
			if ($urandom_range(149) == 0) wait_drained();
			send_request(make_request());
		end
		drain();
	endtask

	initial begin
		sb = new();
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		run_directed();
		run_phase(180, 0);

		set_regs(32'd4095, 32'd4095, 32'd0, 32'd0);
		run_phase(180, 77);

		set_regs(32'd0, 32'd0, 32'd32767, 32'd32767);
		run_phase(180, 22);

		set_regs($urandom, $urandom, $urandom, $urandom);
		run_phase(180, 0);

		set_regs(32'd1, 32'd4095, 32'd200, 32'd1000);
		run_phase(180, 77);

		set_regs($urandom, $urandom, $urandom_range(3000), $urandom_range(3000));
		run_phase(200, 22);

		if (sb.errors == 0 && sb.outstanding() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin
		#400000;
		$display("== FAIL ==");
		$finish;
	end

endmodule
